[hw/rtl/ssr_pkg.sv]
// Package for the stream search-and-replace block: sizes, register indexes, types.
`default_nettype none

package ssr_pkg;

   // Window depth by default, and the width of lengths and counts.
   localparam int MAX_PATTERN_DEF = 16;
   localparam int LEN_W           = 5;
   localparam int REPL_MAX        = 16;
   localparam int STR_BYTES       = 16;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LEN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LO  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_HI  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REP_LEN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REP_LO  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REP_HI  = 3'd5;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_REPL,
      S_HEAD,
      S_FLUSH
   } ssr_state_type;

   // Control shared by every cell of the window chain.
   typedef struct packed {
      logic             load;
      logic             shift;
      logic [LEN_W-1:0] wpos;
      logic [LEN_W-1:0] plen;
   } ssr_cell_ctl_type;

endpackage

`default_nettype wire

[hw/rtl/ssr_req_if.sv]
// Input channel: one byte of a line per word, with its end-of-line flag.
`default_nettype none

interface ssr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       line_end;

   modport source (output valid, output in_byte, output line_end, input ready);
   modport sink   (input valid, input in_byte, input line_end, output ready);
endinterface

`default_nettype wire

[hw/rtl/ssr_rsp_if.sv]
// Result channel: one byte of the rewritten line per word, with its markers.
`default_nettype none

interface ssr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_present;
   logic       run_last;
   logic       line_last;

   modport source (output valid, output out_byte, output byte_present,
                   output run_last, output line_last, input ready);
   modport sink   (input valid, input out_byte, input byte_present,
                   input run_last, input line_last, output ready);
endinterface

`default_nettype wire

[hw/rtl/ssr_cell.sv]
// One cell of the window chain: holds a byte and compares it with its pattern byte.
`default_nettype none

module ssr_cell import ssr_pkg::*; #(
   parameter int INDEX = 0
) (
   input  wire logic             clock,
   input  wire ssr_cell_ctl_type ctl,
   input  wire logic [7:0]       in_byte,
   input  wire logic [7:0]       next_byte,
   input  wire logic [7:0]       pat_byte,
   output logic      [7:0]       byte_q,
   output logic                  eq
);

   localparam logic [LEN_W-1:0] IDX = LEN_W'(INDEX);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic [7:0] cand;
   logic       sel;

   // The compare looks at the byte the cell holds after this cycle's load.
   always_comb begin
      sel  = ctl.load && (ctl.wpos == IDX);
      cand = sel ? in_byte : byte_ff;
      eq   = (cand == pat_byte) || (IDX >= ctl.plen);
      if (sel) begin
         byte_in = in_byte;
      end else if (ctl.shift) begin
         byte_in = next_byte;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign byte_q = byte_ff;

endmodule

`default_nettype wire

[hw/rtl/stream_search_replace_top.sv]
// Top level of the stream search-and-replace block: configuration, sequencer and cell chain.
// The block takes a line one byte per word and replaces the leftmost, non-overlapping
// occurrences of a configured pattern (1 to MAX_PATTERN bytes) by a replacement
// (0 to 16 bytes). Pending bytes sit in a chain of cells, one byte per cell, which shifts
// towards the output. Each result word leaves through a single output register at one word
// per cycle while the receiver keeps ready high: a byte that leaves the window short of the
// pattern length is only stored, one that fills it without a match sends out the oldest
// byte, a match sends the R replacement bytes, and end of line sends the flushed bytes or
// a bare end marker. A new word is taken while the last result still waits in the output
// register. Writing pattern_length discards the pending window.
`default_nettype none

module stream_search_replace_top import ssr_pkg::*; #(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ssr_req_if.sink                    req_chan,
   ssr_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [LEN_W-1:0] PLEN_MAX = LEN_W'(MAX_PATTERN);
   localparam logic [LEN_W-1:0] RLEN_MAX = LEN_W'(REPL_MAX);

   // Configuration registers.
   logic [LEN_W-1:0]      plen_raw_ff;
   logic [LEN_W-1:0]      rlen_raw_ff;
   logic [CSR_DATA_W-1:0] pat_lo_ff;
   logic [CSR_DATA_W-1:0] pat_hi_ff;
   logic [CSR_DATA_W-1:0] rep_lo_ff;
   logic [CSR_DATA_W-1:0] rep_hi_ff;

   // Sequencer state.
   ssr_state_type    state_ff, state_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             eol_ff, eol_in;
   logic             produced_ff, produced_in;

   // Output register.
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_present_ff;
   logic       rsp_run_last_ff;
   logic       rsp_line_last_ff;

   logic             emit;
   logic [7:0]       emit_byte;
   logic             emit_present;
   logic             emit_run_last;
   logic             emit_line_last;
   logic [LEN_W-1:0] plen_eff;
   logic [LEN_W-1:0] rlen_eff;
   logic [LEN_W-1:0] wpos;
   logic [LEN_W-1:0] rest;
   logic             full;
   logic             match;
   logic             slot_free;
   logic             accept;
   logic [7:0]       rep_byte;
   logic [2*CSR_DATA_W-1:0] pat_all;
   logic [2*CSR_DATA_W-1:0] rep_all;
   ssr_cell_ctl_type ctl;

   logic [7:0] cell_byte [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] cell_eq;

   // Effective lengths: a zero pattern length counts as one, both saturate.
   always_comb begin
      if (plen_raw_ff == '0) begin
         plen_eff = LEN_W'(1);
      end else if (plen_raw_ff > PLEN_MAX) begin
         plen_eff = PLEN_MAX;
      end else begin
         plen_eff = plen_raw_ff;
      end
      rlen_eff = (rlen_raw_ff > RLEN_MAX) ? RLEN_MAX : rlen_raw_ff;
   end

   assign pat_all  = {pat_hi_ff, pat_lo_ff};
   assign rep_all  = {rep_hi_ff, rep_lo_ff};
   assign rep_byte = rep_all[{idx_ff[3:0], 3'b000} +: 8];

   // Handshake and window position of the incoming byte.
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign wpos           = (count_ff >= plen_eff) ? '0 : count_ff;
   assign full           = ((wpos + LEN_W'(1)) == plen_eff);
   assign match          = &cell_eq;

   // Chain of cells; each takes its right neighbour's byte on a shift.
   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      logic [7:0] nb;
      if (i < MAX_PATTERN - 1) begin : g_mid
         assign nb = cell_byte[i+1];
      end else begin : g_end
         assign nb = 8'h00;
      end
      ssr_cell #(
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .in_byte   (req_chan.in_byte),
         .next_byte (nb),
         .pat_byte  (pat_all[8*i +: 8]),
         .byte_q    (cell_byte[i]),
         .eq        (cell_eq[i])
      );
   end

   // Next state and emitted word.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      eol_in         = eol_ff;
      produced_in    = produced_ff;
      ctl.load       = 1'b0;
      ctl.shift      = 1'b0;
      ctl.wpos       = wpos;
      ctl.plen       = plen_eff;
      emit           = 1'b0;
      emit_byte      = 8'h00;
      emit_present   = 1'b1;
      emit_run_last  = 1'b0;
      emit_line_last = 1'b0;
      rest           = (count_ff == '0) ? '0 : count_ff - LEN_W'(1);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctl.load    = 1'b1;
               eol_in      = req_chan.line_end;
               produced_in = 1'b0;
               idx_in      = '0;
               if (full && match) begin
                  count_in = '0;
                  state_in = S_REPL;
               end else if (full) begin
                  count_in = plen_eff;
                  state_in = S_HEAD;
               end else begin
                  count_in = wpos + LEN_W'(1);
                  state_in = req_chan.line_end ? S_FLUSH : S_IDLE;
               end
            end
         end
         S_REPL: begin
            if (idx_ff >= rlen_eff) begin
               // Empty replacement: only an end of line still needs a word.
               state_in = (eol_ff && !produced_ff) ? S_FLUSH : S_IDLE;
            end else if (slot_free) begin
               emit           = 1'b1;
               emit_byte      = rep_byte;
               idx_in         = idx_ff + LEN_W'(1);
               produced_in    = 1'b1;
               emit_run_last  = (idx_in == rlen_eff);
               emit_line_last = emit_run_last && eol_ff;
               if (emit_run_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_HEAD: begin
            if (slot_free) begin
               emit           = 1'b1;
               emit_byte      = cell_byte[0];
               ctl.shift      = 1'b1;
               count_in       = rest;
               produced_in    = 1'b1;
               emit_run_last  = !eol_ff || (rest == '0);
               emit_line_last = eol_ff && (rest == '0);
               state_in       = (eol_ff && (rest != '0)) ? S_FLUSH : S_IDLE;
            end
         end
         S_FLUSH: begin
            if (slot_free) begin
               emit = 1'b1;
               if (count_ff == '0) begin
                  // Nothing came out of this line's last byte: bare end marker.
                  emit_present   = 1'b0;
                  emit_run_last  = 1'b1;
                  emit_line_last = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  emit_byte      = cell_byte[0];
                  ctl.shift      = 1'b1;
                  count_in       = rest;
                  emit_run_last  = (rest == '0);
                  emit_line_last = (rest == '0);
                  if (rest == '0) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A new pattern length discards the pending window.
      if (csr_we && (csr_index == CSR_PAT_LEN)) begin
         count_in = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         eol_ff       <= 1'b0;
         produced_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         idx_ff      <= idx_in;
         eol_ff      <= eol_in;
         produced_ff <= produced_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff      <= emit_byte;
         rsp_present_ff   <= emit_present;
         rsp_run_last_ff  <= emit_run_last;
         rsp_line_last_ff <= emit_line_last;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         plen_raw_ff <= LEN_W'(1);
         rlen_raw_ff <= '0;
         pat_lo_ff   <= '0;
         pat_hi_ff   <= '0;
         rep_lo_ff   <= '0;
         rep_hi_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PAT_LEN: plen_raw_ff <= csr_wdata[LEN_W-1:0];
            CSR_PAT_LO:  pat_lo_ff   <= csr_wdata;
            CSR_PAT_HI:  pat_hi_ff   <= csr_wdata;
            CSR_REP_LEN: rlen_raw_ff <= csr_wdata[LEN_W-1:0];
            CSR_REP_LO:  rep_lo_ff   <= csr_wdata;
            CSR_REP_HI:  rep_hi_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_byte     = rsp_byte_ff;
   assign rsp_chan.byte_present = rsp_present_ff;
   assign rsp_chan.run_last     = rsp_run_last_ff;
   assign rsp_chan.line_last    = rsp_line_last_ff;

   // Between words the window never holds a whole pattern length.
   a_idle_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (count_ff < plen_eff))
      else $error("window full while waiting for a word");

   // A bare end marker carries a zero byte and closes both the run and the line.
   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_present_ff) |->
      ((rsp_byte_ff == 8'h00) && rsp_line_last_ff && rsp_run_last_ff))
      else $error("malformed end marker");

   // The last word of a line is always the last word of its run.
   a_line_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_line_last_ff) |-> rsp_run_last_ff)
      else $error("line ended inside a run");

endmodule

`default_nettype wire

[tb/sv/stream_search_replace_checker.sv]
// Checker for the search-and-replace block: predicts the rewritten line and compares each word.
`timescale 1ns / 1ps
`default_nettype none

module stream_search_replace_checker import ssr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ssr_req_if                         req_mon,
   ssr_rsp_if                         rsp_mon,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         mismatch_total,
   output int                         pending_words,
   output int                         words_taken,
   output int                         words_given,
   output int                         lines_seen,
   output int                         matches_seen,
   output int                         settings_seen
);

   // One word of the rewritten line, as it leaves the block.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       run_last;
      logic       line_last;
   } rewrite_word_t;

   localparam int REPORT_LIMIT = 10;

   rewrite_word_t expected_words[$];

   // Our own copy of the registers and of the pending window.
   logic [LEN_W-1:0]      pat_len_reg;
   logic [LEN_W-1:0]      rep_len_reg;
   logic [CSR_DATA_W-1:0] pat_lo;
   logic [CSR_DATA_W-1:0] pat_hi;
   logic [CSR_DATA_W-1:0] rep_lo;
   logic [CSR_DATA_W-1:0] rep_hi;
   logic [7:0]            window_q [STR_BYTES];
   int unsigned           window_fill;

   // Byte k of a sixteen-byte string held as two 64-bit halves.
   function automatic logic [7:0] pick_byte(input logic [63:0] lo, input logic [63:0] hi,
                                            input int unsigned k);
      logic [63:0] half;
      half = (k < 8) ? lo : hi;
      return half[8*(k%8) +: 8];
   endfunction

   // Take one input byte into the window and queue the words that it releases.
   task automatic rewrite_byte(input logic [7:0] in_byte, input logic line_end);
      int unsigned   span;
      int unsigned   rep_span;
      int unsigned   k;
      bit            hit;
      rewrite_word_t w;
      rewrite_word_t burst[$];

      // A zero length behaves as one, and both lengths saturate at the string size.
      span = (pat_len_reg == 0) ? 1 :
             ((pat_len_reg > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : pat_len_reg);
      rep_span = (rep_len_reg > REPL_MAX) ? REPL_MAX : rep_len_reg;

      if (window_fill >= span) begin
         window_fill = 0;
      end
      window_q[window_fill] = in_byte;
      window_fill++;

      // A full window is either replaced whole or gives up its oldest byte.
      if (window_fill == span) begin
         hit = 1'b1;
         for (k = 0; k < span; k++) begin
            if (window_q[k] !== pick_byte(pat_lo, pat_hi, k)) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            matches_seen <= matches_seen + 1;
            for (k = 0; k < rep_span; k++) begin
               w = '{out_byte: pick_byte(rep_lo, rep_hi, k), byte_present: 1'b1,
                     run_last: 1'b0, line_last: 1'b0};
               burst.push_back(w);
            end
            window_fill = 0;
         end else begin
            w = '{out_byte: window_q[0], byte_present: 1'b1, run_last: 1'b0, line_last: 1'b0};
            burst.push_back(w);
            for (k = 0; k < STR_BYTES - 1; k++) begin
               window_q[k] = window_q[k+1];
            end
            window_q[STR_BYTES-1] = 8'h00;
            window_fill--;
         end
      end

      // End of line flushes the window; with nothing to say, a bare end marker goes out.
      if (line_end) begin
         for (k = 0; k < window_fill; k++) begin
            w = '{out_byte: window_q[k], byte_present: 1'b1, run_last: 1'b0, line_last: 1'b0};
            burst.push_back(w);
         end
         window_fill = 0;
         if (burst.size() == 0) begin
            w = '{out_byte: 8'h00, byte_present: 1'b0, run_last: 1'b0, line_last: 1'b0};
            burst.push_back(w);
         end
         w = burst[burst.size()-1];
         w.line_last = 1'b1;
         burst[burst.size()-1] = w;
      end

      if (burst.size() > 0) begin
         w = burst[burst.size()-1];
         w.run_last = 1'b1;
         burst[burst.size()-1] = w;
      end
      foreach (burst[i]) begin
         expected_words.push_back(burst[i]);
      end
   endtask

   // Register writes, then accepted input words, then accepted result words, all at the edge.
   always @(posedge clock) begin : watch_channels
      rewrite_word_t seen;
      rewrite_word_t want;

      if (reset) begin
         pat_len_reg = 5'd1;
         rep_len_reg = '0;
         pat_lo      = '0;
         pat_hi      = '0;
         rep_lo      = '0;
         rep_hi      = '0;
         window_fill = 0;
         foreach (window_q[i]) begin
            window_q[i] = 8'h00;
         end
         expected_words.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PAT_LEN: begin
                  pat_len_reg = csr_wdata[LEN_W-1:0];
                  window_fill = 0;
                  settings_seen <= settings_seen + 1;
               end
               CSR_PAT_LO:  pat_lo = csr_wdata;
               CSR_PAT_HI:  pat_hi = csr_wdata;
               CSR_REP_LEN: rep_len_reg = csr_wdata[LEN_W-1:0];
               CSR_REP_LO:  rep_lo = csr_wdata;
               CSR_REP_HI:  rep_hi = csr_wdata;
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            words_taken <= words_taken + 1;
            if (req_mon.line_end) begin
               lines_seen <= lines_seen + 1;
            end
            rewrite_byte(req_mon.in_byte, req_mon.line_end);
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            words_given <= words_given + 1;
            seen = '{out_byte: rsp_mon.out_byte, byte_present: rsp_mon.byte_present,
                     run_last: rsp_mon.run_last, line_last: rsp_mon.line_last};
            if (expected_words.size() == 0) begin
               mismatch_total <= mismatch_total + 1;
               if (mismatch_total < REPORT_LIMIT) begin
                  $display("%0t: result word with none expected: byte %02h present %0b",
                           $realtime, seen.out_byte, seen.byte_present);
               end
            end else begin
               want = expected_words.pop_front();
               if (seen.out_byte !== want.out_byte || seen.byte_present !== want.byte_present ||
                   seen.run_last !== want.run_last || seen.line_last !== want.line_last) begin
                  mismatch_total <= mismatch_total + 1;
                  if (mismatch_total < REPORT_LIMIT) begin
                     $display("%0t: result word mismatch: expected byte %02h present %0b",
                              $realtime, want.out_byte, want.byte_present,
                              " run_last %0b line_last %0b;", want.run_last, want.line_last,
                              " got byte %02h present %0b run_last %0b line_last %0b",
                              seen.out_byte, seen.byte_present, seen.run_last,
                              seen.line_last);
                  end
               end
            end
         end
      end
      pending_words <= expected_words.size();
   end

endmodule

`default_nettype wire

[tb/sv/stream_search_replace_top_tb.sv]
// Top of the search-and-replace testbench: clock, reset, register settings, line stimulus, verdict.
`timescale 1ns / 1ps
`default_nettype none

module stream_search_replace_top_tb;
   import ssr_pkg::*;

   // How each side of the block paces its words.
   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_GAPS,
      FLOW_RECEIVER_STALLS,
      FLOW_BOTH
   } flow_mode_t;

   // Indexes past the last register; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   localparam int RANDOM_PHASES   = 8;
   localparam int WORDS_PER_PHASE = 60;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_CYCLES     = 300;
   localparam int HOLD_PHASE      = 4;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   flow_mode_t            flow_mode;
   logic                  hold_armed;

   int mismatch_total;
   int pending_words;
   int words_taken;
   int words_given;
   int lines_seen;
   int matches_seen;
   int settings_seen;

   ssr_req_if req_chan ();
   ssr_rsp_if rsp_chan ();

   stream_search_replace_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   stream_search_replace_checker rewrite_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_total (mismatch_total),
      .pending_words  (pending_words),
      .words_taken    (words_taken),
      .words_given    (words_given),
      .lines_seen     (lines_seen),
      .matches_seen   (matches_seen),
      .settings_seen  (settings_seen)
   );

   // Share of cycles, in percent, in which one side holds back.
   function automatic int unsigned idle_share(input flow_mode_t mode, input bit at_receiver);
      case (mode)
         FLOW_SENDER_GAPS:     return at_receiver ? 0 : 71;
         FLOW_RECEIVER_STALLS: return at_receiver ? 71 : 0;
         FLOW_BOTH:            return 14;
         default:              return 0;
      endcase
   endfunction

   // A byte from the line's alphabet: either two symbols or the whole byte range.
   function automatic logic [7:0] draw_symbol(input bit narrow, input logic [7:0] sym_a,
                                              input logic [7:0] sym_b);
      if (narrow) begin
         return ($urandom_range(1) != 0) ? sym_a : sym_b;
      end
      return 8'($urandom_range(255));
   endfunction

   // Clock with a 10 ns period.
   initial begin
      clock = 1'b0;
      forever begin
         #5 clock = ~clock;
      end
   end

   // Give up well beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off that lets the block fill up.
   initial begin : receiver
      int held;
      held = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_armed && held < HOLD_CYCLES) begin
            rsp_chan.ready <= 1'b0;
            held++;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= idle_share(flow_mode, 1'b1));
         end
      end
   end

   // Offer one word and wait for it to be taken; valid stays high for the next word.
   task automatic send_word(input logic [7:0] in_byte, input logic line_end);
      while ($urandom_range(99) < idle_share(flow_mode, 1'b0)) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.in_byte  <= in_byte;
      req_chan.line_end <= line_end;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
   endtask

   // Stop offering, wait for every expected word, then let any silent work finish.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Write every register; optionally poke the unused indexes afterwards.
   task automatic load_setting(input logic [LEN_W-1:0] pat_len, input logic [63:0] pat_lo,
                               input logic [63:0] pat_hi, input logic [LEN_W-1:0] rep_len,
                               input logic [63:0] rep_lo, input logic [63:0] rep_hi,
                               input bit with_spare);
      write_reg(CSR_PAT_LEN, CSR_DATA_W'(pat_len));
      write_reg(CSR_PAT_LO, pat_lo);
      write_reg(CSR_PAT_HI, pat_hi);
      write_reg(CSR_REP_LEN, CSR_DATA_W'(rep_len));
      write_reg(CSR_REP_LO, rep_lo);
      write_reg(CSR_REP_HI, rep_hi);
      if (with_spare) begin
         write_reg(CSR_SPARE_LOW, '1);
         write_reg(CSR_SPARE_HIGH, '1);
      end
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      logic [7:0]       pat [STR_BYTES];
      logic [7:0]       line_q[$];
      logic [7:0]       sym_a;
      logic [7:0]       sym_b;
      logic [LEN_W-1:0] pat_len;
      logic [LEN_W-1:0] rep_len;
      logic [63:0]      pat_lo;
      logic [63:0]      pat_hi;
      bit               narrow;
      int unsigned      span;
      int unsigned      target;
      int unsigned      pick;
      int unsigned      cut;
      int               sent;
      int               k;

      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_chan.valid    = 1'b0;
      req_chan.in_byte  = 8'h00;
      req_chan.line_end = 1'b0;
      flow_mode      = FLOW_FREE;
      hold_armed     = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset setting: pattern is one zero byte, replacement empty. A zero byte vanishes,
      // and a line that ends on one gives only a bare end marker.
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b1);
      send_word(8'h5A, 1'b1);
      drain();

      // "abc" becomes "XY"; pattern bytes past the length hold junk that must not count.
      load_setting(5'd3, 64'hDEAD_BEEF_A5_636261, 64'hFFFF_FFFF_FFFF_FFFF,
                   5'd2, 64'h0000_0000_0000_5958, 64'h0, 1'b1);
      send_word(8'h61, 1'b0);
      send_word(8'h62, 1'b0);
      send_word(8'h63, 1'b0);
      send_word(8'h61, 1'b0);
      send_word(8'h62, 1'b1);
      drain();

      // Zero pattern length acts as one; an oversized replacement gives all sixteen bytes.
      load_setting(5'd0, 64'h0000_0000_0000_00FF, 64'h0,
                   5'd31, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0);
      send_word(8'hFF, 1'b1);
      send_word(8'h00, 1'b1);
      drain();

      // Oversized pattern length saturates to the full window; an empty replacement
      // swallows the whole match.
      load_setting(5'd31, 64'h8040_2010_0804_0201, 64'h7FBF_DFEF_F7FB_FDFE,
                   5'd0, 64'h0, 64'h0, 1'b0);
      for (k = 0; k < 8; k++) begin
         send_word(8'h01 << k, 1'b0);
      end
      for (k = 0; k < 8; k++) begin
         send_word(~(8'h01 << k), 1'b0);
      end
      send_word(8'h01, 1'b1);
      drain();

      // Random settings, each with lines built mostly from the pattern and its prefixes.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         flow_mode <= flow_mode_t'(phase % 4);
         if (phase == HOLD_PHASE) begin
            hold_armed <= 1'b1;
         end

         pick = $urandom_range(9);
         if (pick < 6) begin
            pat_len = LEN_W'($urandom_range(1, 4));
         end else if (pick < 8) begin
            pat_len = LEN_W'($urandom_range(5, 16));
         end else if (pick == 8) begin
            pat_len = LEN_W'(MAX_PATTERN_DEF);
         end else begin
            pat_len = ($urandom_range(1) != 0) ? LEN_W'(0) : LEN_W'($urandom_range(17, 31));
         end
         pick = $urandom_range(9);
         if (pick < 6) begin
            rep_len = LEN_W'($urandom_range(0, 4));
         end else if (pick < 9) begin
            rep_len = LEN_W'($urandom_range(5, 16));
         end else begin
            rep_len = LEN_W'($urandom_range(17, 31));
         end
         span = (pat_len == 0) ? 1 :
                ((pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : pat_len);

         narrow = ($urandom_range(1) != 0);
         sym_a  = 8'($urandom_range(255));
         sym_b  = 8'($urandom_range(255));
         for (k = 0; k < STR_BYTES; k++) begin
            pat[k] = draw_symbol(narrow, sym_a, sym_b);
            if (k < 8) begin
               pat_lo[8*k +: 8] = pat[k];
            end else begin
               pat_hi[8*(k-8) +: 8] = pat[k];
            end
         end
         load_setting(pat_len, pat_lo, pat_hi, rep_len, {$urandom, $urandom},
                      {$urandom, $urandom}, 1'b0);

         // A phase may stop in the middle of a line, leaving a window for the next
         // length write to discard.
         sent = 0;
         while (sent < WORDS_PER_PHASE) begin
            line_q.delete();
            target = $urandom_range(1, 2 * span + 6);
            while (line_q.size() < target) begin
               pick = $urandom_range(9);
               if (pick < 4) begin
                  for (k = 0; k < span; k++) begin
                     line_q.push_back(pat[k]);
                  end
               end else if (pick < 6 && span > 1) begin
                  cut = $urandom_range(1, span - 1);
                  for (k = 0; k < cut; k++) begin
                     line_q.push_back(pat[k]);
                  end
                  line_q.push_back(draw_symbol(narrow, sym_a, sym_b));
               end else begin
                  line_q.push_back(draw_symbol(narrow, sym_a, sym_b));
               end
            end
            for (k = 0; k < line_q.size() && sent < WORDS_PER_PHASE; k++) begin
               send_word(line_q[k], k == line_q.size() - 1);
               sent++;
            end
         end
         drain();
      end

      $display("Run covered %0d input words in %0d complete lines under %0d settings.",
               words_taken, lines_seen, settings_seen);
      $display("It checked %0d result words and saw %0d pattern matches.",
               words_given, matches_seen);
      if (mismatch_total == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
